FILE: hw/rtl/pip_pkg.sv
// Shared types and constants for the point-in-polygon test block.
// Used by pip_ctrl, pip_datapath and point_in_polygon_test; no dependencies.

package pip_pkg;

    // Request command codes
    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_APPEND = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_Z_LOW     = 2'd0;
    localparam logic [1:0] CFG_Z_HIGH    = 2'd1;
    localparam logic [1:0] CFG_Z_LOW_EN  = 2'd2;
    localparam logic [1:0] CFG_Z_HIGH_EN = 2'd3;

    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;
    localparam int Z_BITS         = 32;
    localparam int COUNT_OUT_BITS = 7;

    // Controller to datapath commands
    typedef struct packed {
        logic clear;      // empty the vertex list
        logic append;     // append the request's vertex
        logic start;      // latch query point, rewind the walk
        logic rd_issue;   // read the next stored vertex
        logic out_load;   // load the result register
    } pip_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic list_empty; // no vertices held
        logic walk_done;  // current read address is the last vertex
        logic pipe_busy;  // edge pipeline still holds work
    } pip_stat_t;

endpackage

FILE: hw/rtl/pip_ctrl.sv
// Controller state machine for the point-in-polygon test.
// Depends on pip_pkg for command and status types.

module pip_ctrl
    import pip_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] cmd,
    output logic       out_valid,
    input  logic       out_stall,
    output pip_cmd_t   dp_cmd,
    input  pip_stat_t  dp_stat
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_WALK  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       in_acc;
    logic       slot_free;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign slot_free = !out_valid_reg || !out_stall;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        dp_cmd     = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    dp_cmd.clear  = (cmd == CMD_CLEAR);
                    dp_cmd.append = (cmd == CMD_APPEND);
                    dp_cmd.start  = (cmd == CMD_QUERY);
                    if (cmd == CMD_QUERY)
                    begin
                        state_next = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                dp_cmd.rd_issue = !dp_stat.list_empty;
                if (dp_stat.list_empty || dp_stat.walk_done)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!dp_stat.pipe_busy)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    dp_cmd.out_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Result valid: set on load, cleared when taken
    always_comb
    begin
        priority if (dp_cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

FILE: hw/rtl/pip_datapath.sv
// Datapath for the point-in-polygon test: vertex memory, edge pipeline,
// configuration registers and result register. Depends on pip_pkg.

module pip_datapath
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  pip_cmd_t                  dp_cmd,
    output pip_stat_t                 dp_stat,
    input  logic                      cfg_write_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic [31:0]               coord_x,
    input  logic [31:0]               coord_y,
    input  logic [Z_BITS-1:0]         coord_z,
    input  logic                      z_given,
    output logic                      in_polygon,
    output logic                      in_slab,
    output logic [COUNT_OUT_BITS-1:0] vertex_count,
    output logic                      overflow
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int C  = COORD_BITS;
    localparam int D  = COORD_BITS + 1;
    localparam int P  = 2 * D;

    // Configuration registers
    logic signed [Z_BITS-1:0] z_low_reg;
    logic signed [Z_BITS-1:0] z_high_reg;
    logic                     z_low_en_reg;
    logic                     z_high_en_reg;

    // List state
    logic [CW-1:0] count_reg;
    logic          dropped_reg;
    logic          list_full;

    // Vertex memories
    logic [C-1:0] mem_x [MAX_VERTICES];
    logic [C-1:0] mem_y [MAX_VERTICES];

    // Query latch
    logic signed [C-1:0] in_x;
    logic signed [C-1:0] in_y;
    logic signed [Z_BITS-1:0] in_z;
    logic signed [C-1:0] qx_reg;
    logic signed [C-1:0] qy_reg;
    logic                q_slab_reg;
    logic                q_slab_next;
    logic [CW-1:0]       q_count_reg;
    logic                q_drop_reg;

    // Walk and read stage
    logic [AW-1:0]       rd_addr_reg;
    logic                rd_valid_reg;
    logic                rd_first_reg;
    logic signed [C-1:0] rd_x_reg;
    logic signed [C-1:0] rd_y_reg;
    logic signed [C-1:0] prev_x_reg;
    logic signed [C-1:0] prev_y_reg;

    // Edge stage 1: endpoints and differences
    logic                e1_valid_reg;
    logic signed [C-1:0] e1_x0_reg;
    logic signed [C-1:0] e1_y0_reg;
    logic signed [C-1:0] e1_x1_reg;
    logic signed [C-1:0] e1_y1_reg;
    logic signed [D-1:0] e1_dx_reg;
    logic signed [D-1:0] e1_dy_reg;
    logic signed [D-1:0] e1_dxq_reg;
    logic signed [D-1:0] e1_dyq_reg;

    // Edge stage 2: products and flags
    logic                e2_valid_reg;
    logic signed [P-1:0] e2_p_reg;
    logic signed [P-1:0] e2_q_reg;
    logic                e2_horiz_reg;
    logic                e2_strad_reg;
    logic                e2_upar_reg;
    logic                e2_coin_reg;
    logic                e2_dyneg_reg;
    logic                horiz_next;
    logic                strad_next;
    logic                upar_next;
    logic                coin_next;

    // Crossing parity
    logic parity_reg;
    logic parity_next;
    logic s_eq;
    logic s_gt;

    logic [CW+COUNT_OUT_BITS-1:0] count_wide;

    assign in_x = coord_x[C-1:0];
    assign in_y = coord_y[C-1:0];
    assign in_z = coord_z;

    assign list_full = (count_reg == CW'(MAX_VERTICES));

    assign dp_stat.list_empty = (count_reg == '0);
    assign dp_stat.walk_done  = ((CW'(rd_addr_reg) + CW'(1)) == count_reg);
    assign dp_stat.pipe_busy  = rd_valid_reg || e1_valid_reg || e2_valid_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z_low_reg     <= '0;
            z_high_reg    <= '0;
            z_low_en_reg  <= 1'b0;
            z_high_en_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            unique case (cfg_index)
                CFG_Z_LOW:     z_low_reg     <= cfg_data[Z_BITS-1:0];
                CFG_Z_HIGH:    z_high_reg    <= cfg_data[Z_BITS-1:0];
                CFG_Z_LOW_EN:  z_low_en_reg  <= cfg_data[0];
                CFG_Z_HIGH_EN: z_high_en_reg <= cfg_data[0];
                default:       z_low_reg     <= z_low_reg;
            endcase
        end
    end

    // List count and sticky overflow
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else if (dp_cmd.clear)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else if (dp_cmd.append)
        begin
            if (list_full)
            begin
                dropped_reg <= 1'b1;
            end
            else
            begin
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    // Vertex memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (dp_cmd.append && !list_full)
        begin
            mem_x[count_reg[AW-1:0]] <= in_x;
            mem_y[count_reg[AW-1:0]] <= in_y;
        end
        if (dp_cmd.rd_issue)
        begin
            rd_x_reg <= mem_x[rd_addr_reg];
            rd_y_reg <= mem_y[rd_addr_reg];
        end
    end

    // Slab test on the incoming query
    always_comb
    begin
        q_slab_next = 1'b1;
        if (z_given)
        begin
            if (z_low_en_reg && (in_z < z_low_reg))
            begin
                q_slab_next = 1'b0;
            end
            if (z_high_en_reg && (in_z > z_high_reg))
            begin
                q_slab_next = 1'b0;
            end
        end
    end

    // Query latch
    always_ff @(posedge clk)
    begin
        if (dp_cmd.start)
        begin
            qx_reg      <= in_x;
            qy_reg      <= in_y;
            q_slab_reg  <= q_slab_next;
            q_count_reg <= count_reg;
            q_drop_reg  <= dropped_reg;
        end
    end

    // Walk address and read valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_addr_reg  <= '0;
            rd_valid_reg <= 1'b0;
            rd_first_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= dp_cmd.rd_issue;
            if (dp_cmd.start)
            begin
                rd_addr_reg <= '0;
            end
            else if (dp_cmd.rd_issue)
            begin
                rd_addr_reg <= rd_addr_reg + AW'(1);
            end
            if (dp_cmd.rd_issue)
            begin
                rd_first_reg <= (rd_addr_reg == '0);
            end
        end
    end

    // Stage 1: form edge from previous and current vertex
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_valid_reg <= 1'b0;
        end
        else
        begin
            e1_valid_reg <= rd_valid_reg && !rd_first_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
        begin
            prev_x_reg <= rd_x_reg;
            prev_y_reg <= rd_y_reg;
            e1_x0_reg  <= prev_x_reg;
            e1_y0_reg  <= prev_y_reg;
            e1_x1_reg  <= rd_x_reg;
            e1_y1_reg  <= rd_y_reg;
            e1_dx_reg  <= D'(rd_x_reg) - D'(prev_x_reg);
            e1_dy_reg  <= D'(rd_y_reg) - D'(prev_y_reg);
            e1_dxq_reg <= D'(qx_reg) - D'(prev_x_reg);
            e1_dyq_reg <= D'(qy_reg) - D'(prev_y_reg);
        end
    end

    // Stage 2 flags: horizontal hit, straddle, upper vertex, coincidence
    always_comb
    begin
        horiz_next = (e1_dy_reg == '0) && (qy_reg == e1_y0_reg) &&
                     (((e1_x1_reg > e1_x0_reg) && (qx_reg > e1_x0_reg) &&
                       (qx_reg < e1_x1_reg)) ||
                      ((e1_x1_reg < e1_x0_reg) && (qx_reg < e1_x0_reg) &&
                       (qx_reg > e1_x1_reg)));
        strad_next = ((e1_y0_reg > qy_reg) && (e1_y1_reg < qy_reg)) ||
                     ((e1_y0_reg < qy_reg) && (e1_y1_reg > qy_reg));
        upar_next  = ((qy_reg == e1_y0_reg) && (e1_y0_reg > e1_y1_reg) &&
                      (qx_reg < e1_x0_reg)) ^
                     ((qy_reg == e1_y1_reg) && (e1_y1_reg > e1_y0_reg) &&
                      (qx_reg < e1_x1_reg));
        coin_next  = (qx_reg == e1_x0_reg) && (qy_reg == e1_y0_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e2_valid_reg <= 1'b0;
        end
        else
        begin
            e2_valid_reg <= e1_valid_reg;
        end
    end

    // Stage 2: cross products
    always_ff @(posedge clk)
    begin
        if (e1_valid_reg)
        begin
            e2_p_reg     <= P'(e1_dx_reg) * P'(e1_dyq_reg);
            e2_q_reg     <= P'(e1_dxq_reg) * P'(e1_dy_reg);
            e2_horiz_reg <= horiz_next;
            e2_strad_reg <= strad_next;
            e2_upar_reg  <= upar_next;
            e2_coin_reg  <= coin_next;
            e2_dyneg_reg <= e1_dy_reg[D-1];
        end
    end

    // Stage 3: crossing side and parity update
    assign s_eq = (e2_p_reg == e2_q_reg);
    assign s_gt = e2_dyneg_reg ? (e2_p_reg < e2_q_reg) : (e2_p_reg > e2_q_reg);

    always_comb
    begin
        parity_next = parity_reg;
        if (e2_valid_reg)
        begin
            priority if (e2_horiz_reg || (e2_strad_reg && s_eq) || e2_coin_reg)
            begin
                // boundary contact forces the count to one
                parity_next = 1'b1;
            end
            else
            begin
                parity_next = parity_reg ^ (e2_strad_reg && s_gt) ^ e2_upar_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parity_reg <= 1'b0;
        end
        else if (dp_cmd.start)
        begin
            parity_reg <= 1'b0;
        end
        else
        begin
            parity_reg <= parity_next;
        end
    end

    // Result register
    assign count_wide = {{COUNT_OUT_BITS{1'b0}}, q_count_reg};

    always_ff @(posedge clk)
    begin
        if (dp_cmd.out_load)
        begin
            in_polygon   <= parity_reg;
            in_slab      <= q_slab_reg;
            vertex_count <= count_wide[COUNT_OUT_BITS-1:0];
            overflow     <= q_drop_reg;
        end
    end

endmodule

FILE: hw/rtl/point_in_polygon_test.sv
// Point-in-polygon crossing-number test with optional vertical slab check.
// A clear or append request leaves the block idle for the next request. A
// query reads the stored vertices one per cycle from the vertex memory
// read port and streams each edge through a three-stage edge pipeline
// (differences, cross products, compare and parity update); the memory
// read port sets the one-edge-per-cycle pace, and new requests stall until
// the query's result is loaded. Edges run from vertex j to j+1 only, so a
// closed polygon must repeat its first vertex. The result sits in an output
// register, and the next request is taken while it waits.
// Depends on pip_pkg, pip_ctrl and pip_datapath.

module point_in_polygon_test
    import pip_pkg::*;
#(
    parameter int MAX_VERTICES = 64,
    parameter int COORD_BITS   = 32
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                cmd,
    input  logic [31:0]               coord_x,
    input  logic [31:0]               coord_y,
    input  logic [Z_BITS-1:0]         coord_z,
    input  logic                      z_given,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      in_polygon,
    output logic                      in_slab,
    output logic [COUNT_OUT_BITS-1:0] vertex_count,
    output logic                      overflow,
    input  logic                      cfg_write_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    pip_cmd_t  dp_cmd;
    pip_stat_t dp_stat;

    // Controller
    pip_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .dp_cmd    (dp_cmd),
        .dp_stat   (dp_stat)
    );

    // Datapath
    pip_datapath #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_BITS   (COORD_BITS)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .dp_cmd       (dp_cmd),
        .dp_stat      (dp_stat),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .z_given      (z_given),
        .in_polygon   (in_polygon),
        .in_slab      (in_slab),
        .vertex_count (vertex_count),
        .overflow     (overflow)
    );

endmodule

FILE: test/tb_point_in_polygon_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for point_in_polygon_test: directed requests, then random polygons
// and queries, checked against an in-bench crossing-number predictor.
// Depends on pip_pkg and the point_in_polygon_test RTL.

module tb_point_in_polygon_test;
    import pip_pkg::*;

    localparam int MAX_VERTS     = 64;
    localparam int PHASE_ITEMS   = 250;
    localparam int NUM_PHASES    = 6;
    localparam int NUM_DIRECTED  = 25;
    localparam int IDLE_PCT      = 27;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 80;
    localparam int CYCLE_LIMIT   = 1000000;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic signed [31:0] S_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;

    typedef struct packed {
        logic       poly_hit;
        logic       slab_ok;
        logic [6:0] held;
        logic       dropped;
    } verdict_t;

    typedef struct {
        logic [1:0]         op;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic               zg;
        bit                 typed;
        verdict_t           want;
    } stim_row_t;

    localparam verdict_t NO_CHECK   = '0;
    localparam verdict_t EMPTY_LIST = '{poly_hit: 1'b0, slab_ok: 1'b1, held: 7'd0, dropped: 1'b0};
    localparam verdict_t ONE_VERTEX = '{poly_hit: 1'b0, slab_ok: 1'b1, held: 7'd1, dropped: 1'b0};

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [1:0]                cmd;
    logic [31:0]               coord_x;
    logic [31:0]               coord_y;
    logic [Z_BITS-1:0]         coord_z;
    logic                      z_given;
    logic                      out_valid;
    logic                      out_stall;
    logic                      in_polygon;
    logic                      in_slab;
    logic [COUNT_OUT_BITS-1:0] vertex_count;
    logic                      overflow;
    logic                      cfg_write_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    // Predictor state: vertex list and slab registers
    logic signed [31:0] vert_x [MAX_VERTS];
    logic signed [31:0] vert_y [MAX_VERTS];
    int                 vert_count;
    logic               list_dropped;
    logic signed [31:0] slab_lo;
    logic signed [31:0] slab_hi;
    logic               slab_lo_en;
    logic               slab_hi_en;

    verdict_t verdict_q [$];
    int       error_count;
    int       requests_sent;
    int       cycle_count;
    bit       idle_on;
    bit       hold_req;
    int       hold_left;

    // Directed requests: extremes, every command and the boundary rules on a 10 by 10 square
    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{CMD_QUERY,  0, 0, 0, 1'b0, 1'b1, EMPTY_LIST},
        '{CMD_UNUSED, -1, -1, -1, 1'b1, 1'b0, NO_CHECK},
        '{CMD_APPEND, 0, 0, 0, 1'b0, 1'b0, NO_CHECK},
        '{CMD_QUERY,  5, 5, 0, 1'b0, 1'b1, ONE_VERTEX},
        '{CMD_APPEND, 10, 0, 0, 1'b0, 1'b0, NO_CHECK},
        '{CMD_APPEND, 10, 10, 0, 1'b0, 1'b0, NO_CHECK},
        '{CMD_APPEND, 0, 10, 0, 1'b0, 1'b0, NO_CHECK},
        '{CMD_APPEND, 0, 0, 0, 1'b0, 1'b0, NO_CHECK},
        '{CMD_QUERY,  5, 5, S_MIN, 1'b1, 1'b0, NO_CHECK},
        '{CMD_QUERY,  15, 5, S_MAX, 1'b1, 1'b0, NO_CHECK},
        '{CMD_QUERY,  5, 0, 0, 1'b0, 1'b0, NO_CHECK},
        '{CMD_QUERY,  10, 5, 0, 1'b0, 1'b0, NO_CHECK},
        '{CMD_QUERY,  0, 0, 0, 1'b0, 1'b0, NO_CHECK},
        '{CMD_QUERY,  -5, 10, 0, 1'b0, 1'b0, NO_CHECK},
        '{CMD_CLEAR,  S_MAX, S_MIN, -1, 1'b1, 1'b0, NO_CHECK},
        '{CMD_QUERY,  0, 0, 0, 1'b0, 1'b1, EMPTY_LIST},
        '{CMD_APPEND, S_MIN, S_MIN, 0, 1'b0, 1'b0, NO_CHECK},
        '{CMD_APPEND, S_MAX, S_MIN, 0, 1'b0, 1'b0, NO_CHECK},
        '{CMD_APPEND, S_MAX, S_MAX, 0, 1'b0, 1'b0, NO_CHECK},
        '{CMD_APPEND, S_MIN, S_MAX, 0, 1'b0, 1'b0, NO_CHECK},
        '{CMD_APPEND, S_MIN, S_MIN, 0, 1'b0, 1'b0, NO_CHECK},
        '{CMD_QUERY,  0, 0, -1, 1'b1, 1'b0, NO_CHECK},
        '{CMD_QUERY,  S_MAX, 0, 0, 1'b0, 1'b0, NO_CHECK},
        '{CMD_QUERY,  32'sh8000_0001, 32'sh7FFF_FFFE, 0, 1'b0, 1'b0, NO_CHECK},
        '{CMD_QUERY,  -1, S_MIN, 0, 1'b0, 1'b0, NO_CHECK}
    };

    point_in_polygon_test DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .z_given      (z_given),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .in_polygon   (in_polygon),
        .in_slab      (in_slab),
        .vertex_count (vertex_count),
        .overflow     (overflow),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Crossing parity over edges j -> j+1; boundary hits force the count to one
    function automatic logic crossing_parity(input logic signed [31:0] px,
                                             input logic signed [31:0] py);
        int                 hits;
        int                 sgn;
        logic signed [31:0] ax, ay, bx, by;
        logic signed [67:0] ex, ey, lhs, rhs;
        hits = 0;
        for (int j = 0; j + 1 < vert_count; j++)
        begin
            ax = vert_x[j];
            ay = vert_y[j];
            bx = vert_x[j + 1];
            by = vert_y[j + 1];
            ex = bx - ax;
            ey = by - ay;
            // point on a horizontal edge
            if (ey == 0 && py == ay)
            begin
                if (bx > ax && px > ax && px < bx)
                begin
                    hits = 1;
                    continue;
                end
                if (bx < ax && px < ax && px > bx)
                begin
                    hits = 1;
                    continue;
                end
            end
            // ray crossing, exact cross-multiplied compare
            if (ey != 0 && ((ay > py && by < py) || (ay < py && by > py)))
            begin
                lhs = ex * (py - ay);
                rhs = (px - ax) * ey;
                sgn = (lhs > rhs) ? 1 : ((lhs < rhs) ? -1 : 0);
                if (ey < 0)
                    sgn = -sgn;
                if (sgn > 0)
                    hits++;
                if (sgn == 0)
                begin
                    hits = 1;
                    continue;
                end
            end
            // upper-vertex contact
            if (py == ay && ay > by && px < ax)
                hits++;
            if (py == by && by > ay && px < bx)
                hits++;
            // point sits on the starting vertex
            if (px == ax && py == ay)
            begin
                hits = 1;
                continue;
            end
        end
        return hits[0];
    endfunction

    // Advance the predictor by one accepted request
    function automatic void model_request(input logic [1:0] op,
                                          input logic signed [31:0] x,
                                          input logic signed [31:0] y,
                                          input logic signed [31:0] z,
                                          input logic zg,
                                          output bit produced,
                                          output verdict_t v);
        produced = 1'b0;
        v = '0;
        case (op)
            CMD_CLEAR:
            begin
                vert_count = 0;
                list_dropped = 1'b0;
            end
            CMD_APPEND:
            begin
                if (vert_count >= MAX_VERTS)
                    list_dropped = 1'b1;
                else
                begin
                    vert_x[vert_count] = x;
                    vert_y[vert_count] = y;
                    vert_count++;
                end
            end
            CMD_QUERY:
            begin
                produced = 1'b1;
                v.poly_hit = crossing_parity(x, y);
                v.slab_ok = !(zg && ((slab_lo_en && z < slab_lo) || (slab_hi_en && z > slab_hi)));
                v.held = 7'(vert_count);
                v.dropped = list_dropped;
            end
            default: ;
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    // Offer one request from a falling edge and hold it until taken
    task automatic send_request(input logic [1:0] op, input logic signed [31:0] x,
                                input logic signed [31:0] y, input logic signed [31:0] z,
                                input logic zg, input bit typed, input verdict_t want);
        bit       produced;
        verdict_t v;
        if (idle_on)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                in_valid = 1'b0;
                @(negedge clk);
            end
        end
        cmd = op;
        coord_x = x;
        coord_y = y;
        coord_z = z;
        z_given = zg;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        model_request(op, x, y, z, zg, produced, v);
        if (produced)
            verdict_q.push_back(typed ? want : v);
        if (op != CMD_UNUSED)
            requests_sent++;
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_index = idx;
        cfg_data = data;
        cfg_write_en = 1'b1;
        @(negedge clk);
        cfg_write_en = 1'b0;
        case (idx)
            CFG_Z_LOW:     slab_lo = data;
            CFG_Z_HIGH:    slab_hi = data;
            CFG_Z_LOW_EN:  slab_lo_en = data[0];
            CFG_Z_HIGH_EN: slab_hi_en = data[0];
            default: ;
        endcase
    endtask

    // Wait until every result is back and any trailing append has finished
    task automatic settle();
        in_valid = 1'b0;
        while (verdict_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic signed [31:0] pick_coord(input int mode);
        case (mode)
            0: return 32'(int'($urandom_range(40)) - 20);
            1: return $urandom();
            2:
            begin
                case ($urandom_range(5))
                    0: return S_MIN;
                    1: return S_MAX;
                    2: return 32'sd0;
                    3: return -32'sd1;
                    4: return S_MIN + 1;
                    default: return S_MAX - 1;
                endcase
            end
            default: return 32'(int'($urandom_range(2000)) - 1000);
        endcase
    endfunction

    // Query points lean toward vertices, edge midpoints and vertex rows
    task automatic pick_query(input int mode, output logic signed [31:0] x,
                              output logic signed [31:0] y);
        int r;
        int k;
        r = $urandom_range(9);
        x = pick_coord(mode);
        y = pick_coord(mode);
        if (vert_count > 0 && r < 4)
        begin
            k = $urandom_range(vert_count - 1);
            x = vert_x[k] + ((r == 3) ? 1 : 0);
            y = vert_y[k];
        end
        else if (vert_count > 1 && r < 6)
        begin
            k = $urandom_range(vert_count - 2);
            x = 32'((longint'(vert_x[k]) + longint'(vert_x[k + 1])) >>> 1);
            y = 32'((longint'(vert_y[k]) + longint'(vert_y[k + 1])) >>> 1);
        end
        else if (vert_count > 0 && r < 8)
        begin
            k = $urandom_range(vert_count - 1);
            y = vert_y[k];
        end
    endtask

    task automatic send_query(input int mode);
        logic signed [31:0] x, y, z;
        logic               zg;
        pick_query(mode, x, y);
        zg = ($urandom_range(3) != 0);
        case ($urandom_range(3))
            0: z = $urandom();
            1: z = slab_lo + (int'($urandom_range(2)) - 1);
            2: z = slab_hi + (int'($urandom_range(2)) - 1);
            default: z = pick_coord(2);
        endcase
        send_request(CMD_QUERY, x, y, z, zg, 1'b0, NO_CHECK);
    endtask

    // One random burst: mostly clear, build a polygon, query it; sometimes loose noise
    task automatic run_burst();
        int                 mode;
        int                 nv;
        logic signed [31:0] fx, fy;
        mode = $urandom_range(3);
        if ($urandom_range(99) < 12)
        begin
            repeat ($urandom_range(1, 6))
                send_request(2'($urandom_range(3)), pick_coord(mode), pick_coord(mode),
                             $urandom(), 1'($urandom_range(1)), 1'b0, NO_CHECK);
        end
        else
        begin
            if ($urandom_range(9) != 0)
                send_request(CMD_CLEAR, pick_coord(1), pick_coord(1), $urandom(),
                             1'($urandom_range(1)), 1'b0, NO_CHECK);
            nv = ($urandom_range(24) == 0) ? $urandom_range(60, 70) : $urandom_range(2, 8);
            fx = pick_coord(mode);
            fy = pick_coord(mode);
            send_request(CMD_APPEND, fx, fy, $urandom(), 1'($urandom_range(1)), 1'b0, NO_CHECK);
            for (int i = 1; i < nv; i++)
                send_request(CMD_APPEND, pick_coord(mode), pick_coord(mode), $urandom(),
                             1'($urandom_range(1)), 1'b0, NO_CHECK);
            // close the ring most of the time
            if ($urandom_range(4) != 0)
                send_request(CMD_APPEND, fx, fy, 32'sd0, 1'b0, 1'b0, NO_CHECK);
            repeat ($urandom_range(1, 6))
                send_query(mode);
        end
    endtask

    // Result side: random stalls, plus one long hold-off on request
    initial
    begin
        bit hold_seen;
        out_stall = 1'b0;
        hold_left = 0;
        hold_seen = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_seen)
            begin
                hold_seen = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
                out_stall = idle_on && ($urandom_range(99) < IDLE_PCT);
        end
    end

    // Result checker
    always @(posedge clk)
    begin
        verdict_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (verdict_q.size() == 0)
                flag_mismatch("result with no query outstanding");
            else
            begin
                want = verdict_q.pop_front();
                if (in_polygon !== want.poly_hit)
                    flag_mismatch($sformatf("in_polygon %b, want %b", in_polygon, want.poly_hit));
                if (in_slab !== want.slab_ok)
                    flag_mismatch($sformatf("in_slab %b, want %b", in_slab, want.slab_ok));
                if (vertex_count !== want.held)
                    flag_mismatch($sformatf("vertex_count %0d, want %0d", vertex_count,
                                            want.held));
                if (overflow !== want.dropped)
                    flag_mismatch($sformatf("overflow %b, want %b", overflow, want.dropped));
            end
        end
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("point_in_polygon_test regression: fail");
        $finish;
    end

    // Main sequence
    initial
    begin
        logic signed [31:0] lo, hi;
        logic               le, he;
        int                 target;
        bit                 hold_done;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_CLEAR;
        coord_x = '0;
        coord_y = '0;
        coord_z = '0;
        z_given = 1'b0;
        cfg_write_en = 1'b0;
        cfg_index = CFG_Z_LOW;
        cfg_data = '0;
        vert_count = 0;
        list_dropped = 1'b0;
        slab_lo = '0;
        slab_hi = '0;
        slab_lo_en = 1'b0;
        slab_hi_en = 1'b0;
        error_count = 0;
        requests_sent = 0;
        idle_on = 1'b1;
        hold_req = 1'b0;
        hold_done = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            if (phase > 0)
                settle();
            // slab setting for this phase
            case (phase)
                0: begin lo = 0;        hi = 0;        le = 1'b0; he = 1'b0; end
                1: begin lo = S_MIN;    hi = S_MAX;    le = 1'b1; he = 1'b1; end
                2: begin lo = -1000;    hi = 1000;     le = 1'b1; he = 1'b1; end
                3: begin lo = $urandom(); hi = $urandom(); le = 1'b1; he = 1'b0; end
                4: begin lo = $urandom(); hi = $urandom(); le = 1'b0; he = 1'b1; end
                default: begin lo = S_MAX; hi = S_MIN; le = 1'b1; he = 1'b1; end
            endcase
            write_reg(CFG_Z_LOW, lo);
            write_reg(CFG_Z_HIGH, hi);
            write_reg(CFG_Z_LOW_EN, {{(CFG_DATA_BITS-1){1'b0}}, le});
            write_reg(CFG_Z_HIGH_EN, {{(CFG_DATA_BITS-1){1'b0}}, he});

            if (phase == 0)
            begin
                foreach (directed_rows[i])
                    send_request(directed_rows[i].op, directed_rows[i].x, directed_rows[i].y,
                                 directed_rows[i].z, directed_rows[i].zg,
                                 directed_rows[i].typed, directed_rows[i].want);
            end

            // one phase runs with no idling on either side
            idle_on = (phase != 4);
            target = requests_sent + PHASE_ITEMS;
            while (requests_sent < target)
            begin
                // long receiver hold-off while queries keep coming
                if (phase == 2 && !hold_done && requests_sent + 150 >= target)
                begin
                    hold_done = 1'b1;
                    hold_req = 1'b1;
                    repeat (15) send_query(0);
                end
                run_burst();
            end
        end

        settle();
        if (verdict_q.size() != 0)
            flag_mismatch($sformatf("%0d results never arrived", verdict_q.size()));
        if (error_count == 0)
            $display("point_in_polygon_test regression: pass");
        else
            $display("point_in_polygon_test regression: fail");
        $finish;
    end

endmodule

FILE: point_in_polygon_test.f
hw/rtl/pip_pkg.sv
hw/rtl/pip_ctrl.sv
hw/rtl/pip_datapath.sv
hw/rtl/point_in_polygon_test.sv
test/tb_point_in_polygon_test.sv
